// ----- rtl/double_ended_queue_unit_assert.svh -----
// ---------------------------------------------------------------------------
// Deque assertion macros
// Concurrent assertion shorthands, clocked on the rising edge and held off
// while reset is asserted.
// ---------------------------------------------------------------------------
`ifndef DOUBLE_ENDED_QUEUE_UNIT_ASSERT_SVH
`define DOUBLE_ENDED_QUEUE_UNIT_ASSERT_SVH

// Check a condition at every edge out of reset.
`define DEQ_ASSERT_ALWAYS(lbl, clk_, rst_n_, cond, msg) \
  lbl: assert property (@(posedge clk_) disable iff (!rst_n_) (cond)) else $error(msg);

// Check a consequence in the same cycle as its trigger.
`define DEQ_ASSERT_IMPLY(lbl, clk_, rst_n_, ante, cons, msg) \
  lbl: assert property (@(posedge clk_) disable iff (!rst_n_) (ante) |-> (cons)) \
    else $error(msg);

// Check a consequence in the cycle after its trigger.
`define DEQ_ASSERT_NEXT(lbl, clk_, rst_n_, ante, cons, msg) \
  lbl: assert property (@(posedge clk_) disable iff (!rst_n_) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/deq_pkg.sv -----
// ---------------------------------------------------------------------------
// Deque package
// Field widths, parameter defaults and request/status codes of the deque.
// ---------------------------------------------------------------------------
`default_nettype none

package deq_pkg;

  localparam int unsigned DepthDefault      = 16;
  localparam int unsigned ValueWidthDefault = 64;

  localparam int unsigned ReqW    = 3;
  localparam int unsigned ValueW  = 64;
  localparam int unsigned StatusW = 2;
  localparam int unsigned CountW  = 5;

  typedef enum logic [ReqW-1:0] {
    REQ_PUSH_FRONT = 3'd0,
    REQ_PUSH_BACK  = 3'd1,
    REQ_POP_FRONT  = 3'd2,
    REQ_POP_BACK   = 3'd3,
    REQ_REVERSE    = 3'd4,
    REQ_CLEAR      = 3'd5
  } req_type_t;

  typedef enum logic [StatusW-1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

endpackage

`default_nettype wire

// ----- rtl/deq_if.sv -----
// ---------------------------------------------------------------------------
// Deque channel interfaces
// Valid/ready request and response channels of the deque.
// ---------------------------------------------------------------------------
`default_nettype none

interface deq_req_if import deq_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [ReqW-1:0]   req_type;
  logic [ValueW-1:0] value;

  modport source (output valid, output req_type, output value, input ready);
  modport sink   (input valid, input req_type, input value, output ready);
endinterface

interface deq_rsp_if import deq_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [StatusW-1:0] status;
  logic [CountW-1:0]  entry_count;
  logic               is_empty;
  logic [ValueW-1:0]  front_value;
  logic [ValueW-1:0]  back_value;

  modport source (output valid, output status, output entry_count, output is_empty,
                  output front_value, output back_value, input ready);
  modport sink   (input valid, input status, input entry_count, input is_empty,
                  input front_value, input back_value, output ready);
endinterface

`default_nettype wire

// ----- rtl/deq_ram.sv -----
// ---------------------------------------------------------------------------
// Deque storage RAM
// Generic RAM with one write port and two registered read ports.
// ---------------------------------------------------------------------------
`default_nettype none

module deq_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
  output logic [WIDTH-1:0]         rd_data_a,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
  output logic [WIDTH-1:0]         rd_data_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read-during-write to the same address returns the old contents.
  always_ff @(posedge clk) begin
    rd_data_a <= mem[rd_addr_a];
    rd_data_b <= mem[rd_addr_b];
  end

endmodule

`default_nettype wire

// ----- rtl/double_ended_queue_unit.sv -----
// ---------------------------------------------------------------------------
// Double-ended queue unit
// Bounded deque held as a ring in RAM with head pointer, count and reverse
// flag; one request in, one response out.
// ---------------------------------------------------------------------------
// Usage:
//   in_req  : request beat (req_type, value). Push front/back, pop
//             front/back, reverse, clear. Other codes only report state.
//   out_rsp : response beat (status, entry_count, is_empty, front_value,
//             back_value), one per request, in request order.
//   Path    : an accepted request passes the input register, then the
//             response register, which drives the response beat.
//   Rate    : one request per cycle unless out_rsp.ready stalls. Pointer update,
//             the single RAM write and the end-value update happen together;
//             the front and back values live in registers and the RAM's two
//             read ports prefetch the entries next to each end for the next pop.
//   Reset   : empty queue, head at slot 0, not reversed, no beat pending.
//             RAM contents are not cleared; only held slots are ever read.
//   Stall   : while out_rsp.ready is low the response holds, the input
//             register holds its request, and in_req.ready drops once the
//             input register is full.
// ---------------------------------------------------------------------------
`default_nettype none

module double_ended_queue_unit import deq_pkg::*; #(
  parameter int unsigned DEPTH       = DepthDefault,
  parameter int unsigned VALUE_WIDTH = ValueWidthDefault
) (
  input  logic        clk,
  input  logic        rst_n,
  deq_req_if.sink     in_req,
  deq_rsp_if.source   out_rsp
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  localparam logic [AW-1:0] LastSlot = AW'(DEPTH - 1);
  localparam logic [CW-1:0] DepthC   = CW'(DEPTH);

  // Ring arithmetic on slot indexes, wrapping at DEPTH.
  function automatic logic [AW-1:0] slot_inc(input logic [AW-1:0] s);
    slot_inc = (s == LastSlot) ? '0 : s + 1'b1;
  endfunction

  function automatic logic [AW-1:0] slot_dec(input logic [AW-1:0] s);
    slot_dec = (s == '0) ? LastSlot : s - 1'b1;
  endfunction

  // off never exceeds DEPTH-1, so one conditional subtract wraps the sum.
  function automatic logic [AW-1:0] slot_add(input logic [AW-1:0] base,
                                             input logic [CW-1:0] off);
    logic [CW:0] sum;
    sum = (CW+1)'(base) + (CW+1)'(off);
    if (sum >= (CW+1)'(DEPTH)) begin
      sum = sum - (CW+1)'(DEPTH);
    end
    slot_add = AW'(sum);
  endfunction

  // ---- input register ----
  logic                   s1_valid_r;
  logic [ReqW-1:0]        s1_req_r;
  logic [VALUE_WIDTH-1:0] s1_value_r;
  req_type_t              s1_req_c;
  logic                   s1_adv;

  // ---- queue state ----
  logic [AW-1:0]          head_r, head_nxt;
  logic [CW-1:0]          count_r, count_nxt;
  logic                   rev_r, rev_nxt;
  logic [VALUE_WIDTH-1:0] front_r, front_nxt;   // physical head-slot value
  logic [VALUE_WIDTH-1:0] back_r, back_nxt;     // physical tail-slot value
  logic                   full, empty;
  status_t                status_nxt;

  // ---- RAM ports and read bypass ----
  logic                   wr_en;
  logic [AW-1:0]          wr_addr;
  logic [VALUE_WIDTH-1:0] wr_data;
  logic [AW-1:0]          rd_addr_a, rd_addr_b;
  logic [VALUE_WIDTH-1:0] ram_q_a, ram_q_b;
  logic                   byp_a_r, byp_b_r;
  logic [VALUE_WIDTH-1:0] byp_data_r;
  logic [VALUE_WIDTH-1:0] rd_a, rd_b;           // slots next to head / tail

  // ---- response register ----
  logic                   out_valid_r;
  status_t                out_status_r;
  logic [CW-1:0]          res_count_r;
  logic                   out_is_empty_r;
  logic [VALUE_WIDTH-1:0] res_front_r, res_back_r;
  logic [VALUE_WIDTH-1:0] res_front_nxt, res_back_nxt;

  // Advance the input register when the response register is free or drains.
  assign s1_adv       = s1_valid_r && (!out_valid_r || out_rsp.ready);
  assign in_req.ready = !s1_valid_r || s1_adv;
  assign s1_req_c     = req_type_t'(s1_req_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_req.ready) begin
      s1_valid_r <= in_req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_req.valid && in_req.ready) begin
      s1_req_r   <= in_req.req_type;
      s1_value_r <= in_req.value[VALUE_WIDTH-1:0];   // drop bits above the width
    end
  end

  assign full  = (count_r == DepthC);
  assign empty = (count_r == '0);

  // Prefetched neighbors; take the write data when the read hit the slot
  // written at the same edge.
  assign rd_a = byp_a_r ? byp_data_r : ram_q_a;
  assign rd_b = byp_b_r ? byp_data_r : ram_q_b;

  // Next queue state for the request in the input register.
  always_comb begin
    head_nxt   = head_r;
    count_nxt  = count_r;
    rev_nxt    = rev_r;
    front_nxt  = front_r;
    back_nxt   = back_r;
    status_nxt = ST_DONE;
    wr_en      = 1'b0;
    wr_addr    = head_r;
    wr_data    = s1_value_r;
    if (s1_adv) begin
      case (s1_req_c)
        REQ_PUSH_FRONT, REQ_PUSH_BACK: begin
          if (full) begin
            status_nxt = ST_FULL;
          end else begin
            wr_en     = 1'b1;
            count_nxt = count_r + 1'b1;
            if ((s1_req_c == REQ_PUSH_FRONT) == !rev_r) begin
              // new value becomes the physical head slot
              head_nxt  = slot_dec(head_r);
              wr_addr   = slot_dec(head_r);
              front_nxt = s1_value_r;
              if (empty) begin
                back_nxt = s1_value_r;
              end
            end else begin
              wr_addr  = slot_add(head_r, count_r);
              back_nxt = s1_value_r;
              if (empty) begin
                front_nxt = s1_value_r;
              end
            end
          end
        end
        REQ_POP_FRONT, REQ_POP_BACK: begin
          if (empty) begin
            status_nxt = ST_EMPTY;
          end else begin
            count_nxt = count_r - 1'b1;
            if ((s1_req_c == REQ_POP_FRONT) == !rev_r) begin
              head_nxt  = slot_inc(head_r);
              front_nxt = rd_a;
            end else begin
              back_nxt = rd_b;
            end
          end
        end
        REQ_REVERSE: begin
          if (empty) begin
            status_nxt = ST_EMPTY;
          end else begin
            rev_nxt = !rev_r;
          end
        end
        REQ_CLEAR: begin
          head_nxt  = '0;
          count_nxt = '0;
          rev_nxt   = 1'b0;
        end
        default: begin
          // unknown code: report state, change nothing
        end
      endcase
    end
  end

  // Prefetch the slots next to both ends of the next state.
  always_comb begin
    rd_addr_a = slot_inc(head_nxt);
    rd_addr_b = head_nxt;
    if (count_nxt >= CW'(2)) begin
      rd_addr_b = slot_add(head_nxt, count_nxt - CW'(2));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      count_r <= '0;
      rev_r   <= 1'b0;
      byp_a_r <= 1'b0;
      byp_b_r <= 1'b0;
    end else begin
      head_r  <= head_nxt;
      count_r <= count_nxt;
      rev_r   <= rev_nxt;
      byp_a_r <= wr_en && (wr_addr == rd_addr_a);
      byp_b_r <= wr_en && (wr_addr == rd_addr_b);
    end
  end

  always_ff @(posedge clk) begin
    front_r    <= front_nxt;
    back_r     <= back_nxt;
    byp_data_r <= wr_data;
  end

  deq_ram #(
    .WIDTH (VALUE_WIDTH),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk       (clk),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .rd_addr_a (rd_addr_a),
    .rd_data_a (ram_q_a),
    .rd_addr_b (rd_addr_b),
    .rd_data_b (ram_q_b)
  );

  // Map physical ends to logical front/back; zero when empty.
  always_comb begin
    res_front_nxt = '0;
    res_back_nxt  = '0;
    if (count_nxt != '0) begin
      res_front_nxt = rev_nxt ? back_nxt : front_nxt;
      res_back_nxt  = rev_nxt ? front_nxt : back_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= 1'b1;
    end else if (out_rsp.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_status_r   <= status_nxt;
      res_count_r    <= count_nxt;
      out_is_empty_r <= (count_nxt == '0);
      res_front_r    <= res_front_nxt;
      res_back_r     <= res_back_nxt;
    end
  end

  assign out_rsp.valid       = out_valid_r;
  assign out_rsp.status      = out_status_r;
  assign out_rsp.entry_count = CountW'(res_count_r);
  assign out_rsp.is_empty    = out_is_empty_r;
  assign out_rsp.front_value = ValueW'(res_front_r);
  assign out_rsp.back_value  = ValueW'(res_back_r);

  // ---- assertions ----
`include "double_ended_queue_unit_assert.svh"

  `DEQ_ASSERT_ALWAYS(a_count_bound, clk, rst_n, count_r <= DepthC, "deque count above depth")
  `DEQ_ASSERT_NEXT(a_reject_keeps, clk, rst_n, s1_adv && (status_nxt != ST_DONE), (count_r == $past(count_r)) && (head_r == $past(head_r)) && (rev_r == $past(rev_r)), "rejected request changed queue state")
  `DEQ_ASSERT_IMPLY(a_reverse_empty_rejects, clk, rst_n, s1_adv && (s1_req_c == REQ_REVERSE) && empty, status_nxt == ST_EMPTY, "reverse on an empty queue not rejected")

endmodule

`default_nettype wire

// ----- bench/double_ended_queue_unit_tb.sv -----
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Double-ended queue unit testbench
// Drives push, pop, reverse, clear and unused request codes into the deque.
// Random gaps are put on the request side and random stalls on the response
// side. A mirror of the ring, head, count and direction flag predicts every
// response, and each response beat is compared field by field in order.
// ---------------------------------------------------------------------------
module double_ended_queue_unit_tb;
  import deq_pkg::*;

  localparam int unsigned RING_SLOTS  = 16;
  localparam int unsigned CYCLE_LIMIT = 1_000_000;
  localparam int unsigned RAND_ITEMS  = 1250;
  localparam logic [2:0]  REQ_UNUSED_A = 3'd6;
  localparam logic [2:0]  REQ_UNUSED_B = 3'd7;

  typedef struct {
    status_t           status;
    logic [CountW-1:0] count;
    logic              empty;
    logic [ValueW-1:0] front;
    logic [ValueW-1:0] back;
  } deq_rsp_t;

  // Mirror of the deque plus the list of responses still owed by the block.
  class deque_tracker;
    logic [ValueW-1:0] ring [RING_SLOTS];
    logic [3:0]        head;
    logic [CountW-1:0] held;
    logic              reversed;
    deq_rsp_t          owed_rsp [$];
    int unsigned       mismatches;
    int unsigned       checked;
    int unsigned       full_rejects;
    int unsigned       empty_rejects;
    int unsigned       flips;
    int unsigned       clears;
    int unsigned       peak;

    function new();
      head = '0;
      held = '0;
      reversed = 1'b0;
      mismatches = 0;
      checked = 0;
      full_rejects = 0;
      empty_rejects = 0;
      flips = 0;
      clears = 0;
      peak = 0;
    endfunction

    task report_mismatch(input string msg);
      mismatches++;
      $display("[%0t] MISMATCH: %s", $realtime, msg);
    endtask

    // Apply one accepted request to the mirror and queue its response.
    task note_request(input logic [ReqW-1:0] code, input logic [ValueW-1:0] val);
      deq_rsp_t    rsp;
      logic [3:0]  slot;
      logic [CountW-1:0] last;
      rsp.status = ST_DONE;
      case (code)
        REQ_PUSH_FRONT, REQ_PUSH_BACK: begin
          if (held == CountW'(RING_SLOTS)) begin
            rsp.status = ST_FULL;
          end else if ((code == REQ_PUSH_FRONT) == !reversed) begin
            head = head - 4'd1;
            ring[head] = val;
            held++;
          end else begin
            slot = head + held[3:0];
            ring[slot] = val;
            held++;
          end
        end
        REQ_POP_FRONT, REQ_POP_BACK: begin
          if (held == '0) begin
            rsp.status = ST_EMPTY;
          end else if ((code == REQ_POP_FRONT) == !reversed) begin
            head = head + 4'd1;
            held--;
          end else begin
            held--;
          end
        end
        REQ_REVERSE: begin
          if (held == '0) begin
            rsp.status = ST_EMPTY;
          end else begin
            reversed = ~reversed;
            flips++;
          end
        end
        REQ_CLEAR: begin
          held = '0;
          head = '0;
          reversed = 1'b0;
          clears++;
        end
        default: ;
      endcase
      if (rsp.status == ST_FULL) full_rejects++;
      if (rsp.status == ST_EMPTY) empty_rejects++;
      if (held > peak) peak = held;

      rsp.count = held;
      rsp.empty = (held == '0);
      rsp.front = '0;
      rsp.back  = '0;
      if (held != '0) begin
        last = held - 1'b1;
        slot = head + last[3:0];
        // Physical head slot is the front unless the order is flipped.
        rsp.front = reversed ? ring[slot] : ring[head];
        rsp.back  = reversed ? ring[head] : ring[slot];
      end
      owed_rsp.push_back(rsp);
    endtask

    // Compare one response beat with the oldest owed response.
    task check_response(input logic [StatusW-1:0] status, input logic [CountW-1:0] count,
                        input logic empty, input logic [ValueW-1:0] front,
                        input logic [ValueW-1:0] back);
      deq_rsp_t exp_rsp;
      if (owed_rsp.size() == 0) begin
        report_mismatch("response beat with no request outstanding");
        return;
      end
      exp_rsp = owed_rsp.pop_front();
      if (status !== exp_rsp.status)
        report_mismatch($sformatf("rsp %0d status got %0d expected %0d",
                                  checked, status, exp_rsp.status));
      if (count !== exp_rsp.count)
        report_mismatch($sformatf("rsp %0d entry_count got %0d expected %0d",
                                  checked, count, exp_rsp.count));
      if (empty !== exp_rsp.empty)
        report_mismatch($sformatf("rsp %0d is_empty got %b expected %b",
                                  checked, empty, exp_rsp.empty));
      if (front !== exp_rsp.front)
        report_mismatch($sformatf("rsp %0d front_value got %h expected %h",
                                  checked, front, exp_rsp.front));
      if (back !== exp_rsp.back)
        report_mismatch($sformatf("rsp %0d back_value got %h expected %h",
                                  checked, back, exp_rsp.back));
      checked++;
    endtask
  endclass

  logic clk;
  logic rst_n;

  deq_req_if in_req ();
  deq_rsp_if out_rsp ();

  double_ended_queue_unit DUT (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_req  (in_req),
    .out_rsp (out_rsp)
  );

  deque_tracker tracker;

  // Idle percentages, reshuffled per burst; zero gives a gap-free stretch.
  int unsigned req_idle_pct;
  int unsigned rsp_stall_pct;
  int unsigned rsp_stall_left;
  int unsigned cycles;

  initial clk = 1'b0;
  always #2 clk = ~clk;

  // Mostly short gaps, now and then a long one.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 80) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [ValueW-1:0] pick_value();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 4) return '0;
    if (r < 8) return '1;
    if (r < 12) return ValueW'(1) << $urandom_range(0, ValueW - 1);
    return {$urandom(), $urandom()};
  endfunction

  // Offer one request beat and hold it until the block takes it.
  task send_req(input logic [ReqW-1:0] code, input logic [ValueW-1:0] val);
    bit taken;
    int unsigned gap;
    taken = 1'b0;
    if ($urandom_range(0, 99) < req_idle_pct) begin
      gap = pick_gap();
      in_req.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_req.valid    <= 1'b1;
    in_req.req_type <= code;
    in_req.value    <= val;
    // Sample ready mid-cycle; the beat moves at the following rising edge.
    while (!taken) begin
      @(negedge clk);
      taken = (in_req.ready === 1'b1);
      @(posedge clk);
    end
    tracker.note_request(code, val);
  endtask

  // Response-side backpressure: random stalls of random length.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_rsp.ready <= 1'b0;
      rsp_stall_left = 0;
    end else if (rsp_stall_left > 0) begin
      rsp_stall_left--;
      out_rsp.ready <= 1'b0;
    end else if ($urandom_range(0, 99) < rsp_stall_pct) begin
      rsp_stall_left = pick_gap() - 1;
      out_rsp.ready <= 1'b0;
    end else begin
      out_rsp.ready <= 1'b1;
    end
  end

  // Check each response beat mid-cycle, ahead of the edge that moves it.
  always @(negedge clk) begin
    if (rst_n && out_rsp.valid === 1'b1 && out_rsp.ready === 1'b1)
      tracker.check_response(out_rsp.status, out_rsp.entry_count, out_rsp.is_empty,
                             out_rsp.front_value, out_rsp.back_value);
  end

  // Watchdog: drop the run if it hangs.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d responses owed",
               cycles, tracker.owed_rsp.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  task run_directed();
    int unsigned i;
    // Rejections and unused codes on an empty queue.
    send_req(REQ_POP_FRONT, '0);
    send_req(REQ_POP_BACK, '1);
    send_req(REQ_REVERSE, '0);
    send_req(REQ_UNUSED_A, '1);
    // Extreme values at both ends, flip, then pop through the flipped order.
    send_req(REQ_PUSH_FRONT, '1);
    send_req(REQ_PUSH_BACK, '0);
    send_req(REQ_REVERSE, '0);
    send_req(REQ_UNUSED_B, '0);
    send_req(REQ_POP_FRONT, '0);
    // Fill to the brim from both ends while flipped, then overflow.
    for (i = 0; i < RING_SLOTS - 1; i++)
      send_req(i[0] ? REQ_PUSH_BACK : REQ_PUSH_FRONT, ValueW'(1) << (i * 4 + 3));
    send_req(REQ_PUSH_FRONT, 64'hDEAD_BEEF_0123_4567);
    send_req(REQ_CLEAR, '1);
  endtask

  // Bursts lean toward filling, draining or neither, so both the full and
  // the empty boundary are crossed many times.
  task run_random();
    int unsigned sent;
    int unsigned burst;
    int unsigned lean;
    int unsigned r;
    logic [ReqW-1:0] code;
    sent = 0;
    while (sent < RAND_ITEMS) begin
      burst = $urandom_range(20, 60);
      lean = $urandom_range(0, 2);
      case ($urandom_range(0, 2))
        0: req_idle_pct = 0;
        1: req_idle_pct = 10;
        default: req_idle_pct = 40;
      endcase
      case ($urandom_range(0, 2))
        0: rsp_stall_pct = 0;
        1: rsp_stall_pct = 15;
        default: rsp_stall_pct = 50;
      endcase
      repeat (burst) begin
        r = $urandom_range(0, 99);
        if (r < 1) begin
          code = REQ_CLEAR;
        end else if (r < 3) begin
          code = r[0] ? REQ_UNUSED_A : REQ_UNUSED_B;
        end else if (r < 11) begin
          code = REQ_REVERSE;
        end else begin
          r = $urandom_range(0, 99);
          case (lean)
            0: code = (r < 70) ? REQ_PUSH_FRONT : REQ_POP_FRONT;
            1: code = (r < 30) ? REQ_PUSH_FRONT : REQ_POP_FRONT;
            default: code = (r < 50) ? REQ_PUSH_FRONT : REQ_POP_FRONT;
          endcase
          // Pick the end at random: front codes plus one are the back codes.
          if ($urandom_range(0, 1) == 1) code = code + 3'd1;
        end
        send_req(code, pick_value());
        sent++;
      end
    end
  endtask

  initial begin
    tracker = new();
    cycles = 0;
    rst_n = 1'b0;
    req_idle_pct = 20;
    rsp_stall_pct = 20;
    rsp_stall_left = 0;
    in_req.valid = 1'b0;
    in_req.req_type = REQ_PUSH_FRONT;
    in_req.value = '0;
    out_rsp.ready = 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    run_directed();
    run_random();
    in_req.valid <= 1'b0;

    // Drain, then keep running to catch any stray beat.
    while (tracker.owed_rsp.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("Checked %0d responses; peak fill %0d of %0d, %0d flips, %0d clears",
             tracker.checked, tracker.peak, RING_SLOTS, tracker.flips, tracker.clears);
    $display("Rejected %0d pushes when full and %0d pops/flips when empty; %0d mismatches",
             tracker.full_rejects, tracker.empty_rejects, tracker.mismatches);
    if (tracker.mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
